/* rtl/assert_macros.svh */
// Assertion macros for the task scheduler checker.
// No dependencies; included by the checker only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock and active-low reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scheduler assertion failed");

// Same, on the house clock and reset names.
`define ASSERT_STD(lbl, prop) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

/* rtl/tps_pkg.sv */
// Shared types and constants for the task priority scheduler.
// No dependencies; imported by every module of the block.
package tps_pkg;

  // field widths of the words on the channels
  localparam int OP_W       = 2;
  localparam int TASK_ID_W  = 10;
  localparam int USER_ID_W  = 16;
  localparam int PRIO_REQ_W = 30;

  // parameter defaults
  localparam int TASK_SLOTS_DEF    = 1024;
  localparam int PRIORITY_BITS_DEF = 30;
  localparam int OWNER_BITS_DEF    = 16;

  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_EDIT   = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EXEC   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_CLAIM,
    ST_EMIT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic clear;       // clearing pass: write live=0 at counter, step counter
    logic accept;      // input word taken this cycle
    logic scan_start;  // accepted word is execute-top
    logic scan_step;   // read slot at counter, step counter
    logic claim;       // retire the winner, fetch its owner
    logic emit;        // load the output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic cnt_last;    // counter at the last slot
    logic out_free;    // output register can take a word this cycle
  } sts_t;

endpackage

/* rtl/tps_ctrl.sv */
// Sequencer for the task priority scheduler.
// Depends on tps_pkg; drives tps_datapath through cmd_t.
module tps_ctrl
  import tps_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] op_i,
  output logic            in_stall_o,
  input  sts_t            sts_i,
  output cmd_t            cmd_o
);

  state_e state_q, state_d;
  logic   is_exec;

  assign is_exec = (op_e'(op_i) == OP_EXEC);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (sts_i.cnt_last) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i && is_exec) state_d = ST_SCAN;
      ST_SCAN:  if (sts_i.cnt_last) state_d = ST_FLUSH;
      ST_FLUSH: state_d = ST_CLAIM;
      ST_CLAIM: state_d = ST_EMIT;
      ST_EMIT:  if (sts_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_stall_o       = 1'b0;
        cmd_o.accept     = in_valid_i;
        cmd_o.scan_start = in_valid_i && is_exec;
      end
      ST_SCAN:  cmd_o.scan_step = 1'b1;
      ST_FLUSH: ;
      ST_CLAIM: cmd_o.claim = 1'b1;
      ST_EMIT:  cmd_o.emit = sts_i.out_free;
      default:  ;
    endcase
  end

endmodule

/* rtl/tps_datapath.sv */
// Task table memories, scan comparator and output register.
// Depends on tps_pkg; commanded by tps_ctrl.
module tps_datapath
  import tps_pkg::*;
#(
  parameter int TASK_SLOTS    = TASK_SLOTS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int OWNER_BITS    = OWNER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [TASK_ID_W-1:0]  task_id_i,
  input  logic [USER_ID_W-1:0]  user_id_i,
  input  logic [PRIO_REQ_W-1:0] priority_req_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o,
  output logic [USER_ID_W-1:0]  owner_out_o,
  output logic [TASK_ID_W-1:0]  task_out_o
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  logic                     live_mem  [TASK_SLOTS];
  logic [PRIORITY_BITS-1:0] prio_mem  [TASK_SLOTS];
  logic [OWNER_BITS-1:0]    owner_mem [TASK_SLOTS];

  logic [IDX_W-1:0]         cnt_q;
  logic                     cmp_vld_q;
  logic [IDX_W-1:0]         rd_idx_q;
  logic                     live_rd_q;
  logic [PRIORITY_BITS-1:0] prio_rd_q;
  logic [OWNER_BITS-1:0]    owner_rd_q;
  logic                     have_q;
  logic [IDX_W-1:0]         best_q;
  logic [PRIORITY_BITS-1:0] best_prio_q;
  logic                     out_valid_q;
  logic                     found_q;
  logic [USER_ID_W-1:0]     owner_out_q;
  logic [TASK_ID_W-1:0]     task_out_q;

  logic             in_range, wr_ok, better;
  logic [IDX_W-1:0] wr_idx;
  logic             live_we, live_wd, prio_we, owner_we;
  logic [IDX_W-1:0] live_wa;
  op_e              op;

  assign op       = op_e'(op_i);
  assign in_range = (32'(task_id_i) < 32'(TASK_SLOTS));
  assign wr_idx   = IDX_W'(task_id_i);
  assign wr_ok    = cmd_i.accept && in_range && (op != OP_EXEC);

  assign sts_o.cnt_last = (cnt_q == LAST_IDX);
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  // single write port per memory; sources are exclusive by state
  always_comb begin
    live_we  = 1'b0;
    live_wa  = wr_idx;
    live_wd  = 1'b0;
    prio_we  = 1'b0;
    owner_we = 1'b0;
    if (cmd_i.clear) begin
      live_we = 1'b1;
      live_wa = cnt_q;
    end else if (cmd_i.claim) begin
      live_we = have_q;
      live_wa = best_q;
    end else if (wr_ok) begin
      live_we = 1'b1;
      unique case (op)
        OP_ADD: begin
          live_wd  = 1'b1;
          prio_we  = 1'b1;
          owner_we = 1'b1;
        end
        OP_EDIT: begin
          live_wd = 1'b1;
          prio_we = 1'b1;
        end
        OP_REMOVE: live_wd = 1'b0;
        OP_EXEC:   live_we = 1'b0;
        default:   live_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (live_we) live_mem[live_wa] <= live_wd;
    if (prio_we) prio_mem[wr_idx] <= PRIORITY_BITS'(priority_req_i);
    if (owner_we) owner_mem[wr_idx] <= OWNER_BITS'(user_id_i);
    live_rd_q  <= live_mem[cnt_q];
    prio_rd_q  <= prio_mem[cnt_q];
    owner_rd_q <= owner_mem[best_q];
    rd_idx_q   <= cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_step;
      if (cmd_i.scan_start) begin
        cnt_q <= '0;
      end else if (cmd_i.clear || cmd_i.scan_step) begin
        cnt_q <= sts_o.cnt_last ? '0 : cnt_q + 1'b1;
      end
    end
  end

  // ascending scan with >= leaves the highest id among equal priorities
  assign better = cmp_vld_q && live_rd_q && (!have_q || (prio_rd_q >= best_prio_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (cmd_i.scan_start) begin
      have_q <= 1'b0;
    end else if (better) begin
      have_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (better) begin
      best_q      <= rd_idx_q;
      best_prio_q <= prio_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      found_q     <= have_q;
      owner_out_q <= have_q ? USER_ID_W'(owner_rd_q) : '0;
      task_out_q  <= have_q ? TASK_ID_W'(best_q) : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign owner_out_o = owner_out_q;
  assign task_out_o  = task_out_q;

endmodule

/* rtl/task_priority_scheduler.sv */
// Task priority scheduler: top level joining sequencer and datapath.
// Depends on tps_pkg, tps_ctrl and tps_datapath.
//
// Keeps a table of TASK_SLOTS tasks, each with a live mark, a priority and
// an owner. Add, edit and remove give no result word and do not stall the
// request side; edit also revives a task. Execute-top reads the live and
// priority memories one slot per cycle over the whole table, followed by a
// pipeline flush, a claim step (the winner's live mark is cleared and its
// owner read) and the output load, which presents the result word. The
// request side opens again in the cycle the result word appears, so no new
// request word is taken while an execute-top is in progress. If the output
// register still holds an untaken word, the output load and the request
// side both wait for it. Ties in priority go to the higher task id; an empty
// table gives found=0 with zero id and owner. After reset the block clears
// the live mark of every slot with in_stall_o held high. The output register
// lets add, edit or remove words be taken while a result word is still
// waiting downstream.
module task_priority_scheduler
  import tps_pkg::*;
#(
  parameter int TASK_SLOTS    = TASK_SLOTS_DEF,
  parameter int PRIORITY_BITS = PRIORITY_BITS_DEF,
  parameter int OWNER_BITS    = OWNER_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // request channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [OP_W-1:0]       op_i,
  input  logic [TASK_ID_W-1:0]  task_id_i,
  input  logic [USER_ID_W-1:0]  user_id_i,
  input  logic [PRIO_REQ_W-1:0] priority_req_i,
  // result channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic                  found_o,
  output logic [USER_ID_W-1:0]  owner_out_o,
  output logic [TASK_ID_W-1:0]  task_out_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: clearing pass, idle/accept, scan, flush, claim, output load
  tps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // memories, slot counter, running maximum and output register
  tps_datapath #(
    .TASK_SLOTS    (TASK_SLOTS),
    .PRIORITY_BITS (PRIORITY_BITS),
    .OWNER_BITS    (OWNER_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .task_id_i      (task_id_i),
    .user_id_i      (user_id_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .owner_out_o    (owner_out_o),
    .task_out_o     (task_out_o)
  );

endmodule

/* rtl/tps_checker.sv */
// Port-level checker for the task priority scheduler, bound to the top.
// Depends on tps_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tps_checker
  import tps_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic [OP_W-1:0]       op_i,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic                  found_o,
  input logic [USER_ID_W-1:0]  owner_out_o,
  input logic [TASK_ID_W-1:0]  task_out_o
);

  logic exec_acc, upd_acc;
  logic [USER_ID_W+TASK_ID_W:0] out_word;

  assign exec_acc = in_valid_i && !in_stall_o && (op_i == OP_EXEC);
  assign upd_acc  = in_valid_i && !in_stall_o && (op_i != OP_EXEC);
  assign out_word = {found_o, owner_out_o, task_out_o};

  // a miss carries zero id and owner
  `ASSERT_STD(a_miss_zero, out_valid_o && !found_o |-> owner_out_o == '0 && task_out_o == '0)
  // a stalled result word holds
  `ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word))
  // execute-top starts a scan: no word taken next cycle
  `ASSERT_STD(a_exec_busy, exec_acc |=> in_stall_o)
  // a table update leaves the request side open
  `ASSERT_STD(a_upd_single, upd_acc |=> !in_stall_o)

endmodule

bind task_priority_scheduler tps_checker u_tps_checker (.*);

/* verif/task_priority_scheduler_tb.sv */
// Self-checking testbench for the task priority scheduler.
// Needs tps_pkg and task_priority_scheduler; keeps its own table copy for prediction.
`timescale 1ns / 100ps

module task_priority_scheduler_tb;
  import tps_pkg::*;

  localparam int SLOTS     = TASK_SLOTS_DEF;
  localparam int PRIO_BITS = PRIORITY_BITS_DEF;
  localparam int OWN_BITS  = OWNER_BITS_DEF;
  // Slowest legal run: every word an execute-top, each waiting out the
  // scan, the longest receiver hold-off and the sender gaps, taken ~4x over.
  localparam int CYCLE_LIMIT = 2_500_000;

  // one result word as the block presents it
  typedef struct packed {
    logic                 found;
    logic [USER_ID_W-1:0] owner;
    logic [TASK_ID_W-1:0] id;
  } result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [OP_W-1:0]       op_i;
  logic [TASK_ID_W-1:0]  task_id_i;
  logic [USER_ID_W-1:0]  user_id_i;
  logic [PRIO_REQ_W-1:0] priority_req_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  found_o;
  logic [USER_ID_W-1:0]  owner_out_o;
  logic [TASK_ID_W-1:0]  task_out_o;

  // Shadow of the task table, updated as each request word is accepted.
  logic                 live_tbl  [SLOTS];
  logic [PRIO_BITS-1:0] prio_tbl  [SLOTS];
  logic [OWN_BITS-1:0]  owner_tbl [SLOTS];
  // Owner is only written by add; edits are aimed at these ids alone so
  // that an unwritten owner can never be executed.
  bit                   owner_known [SLOTS];
  logic [TASK_ID_W-1:0] known_ids [$];

  result_t pending_results [$];   // winners predicted, not yet seen
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  int      tx_idle_pct    = 0;    // chance of a gap before each word
  int      rx_stall_pct   = 0;    // chance of stalling the result channel
  int      hold_left      = 0;    // cycles of forced result stall left

  task_priority_scheduler i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .task_id_i      (task_id_i),
    .user_id_i      (user_id_i),
    .priority_req_i (priority_req_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .owner_out_o    (owner_out_o),
    .task_out_o     (task_out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result-side stall: a counted hold-off takes precedence over random stalls.
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Update the shadow table with one accepted word; an execute-top scans for
  // the highest live priority (ties to the higher id) and retires the winner.
  task automatic apply_request(op_e op, logic [TASK_ID_W-1:0] id,
                               logic [USER_ID_W-1:0] user,
                               logic [PRIO_REQ_W-1:0] prio);
    result_t              win;
    logic [PRIO_BITS-1:0] best;
    win  = '0;
    best = '0;
    case (op)
      OP_ADD: begin
        owner_tbl[id] = user[OWN_BITS-1:0];
        prio_tbl[id]  = prio[PRIO_BITS-1:0];
        live_tbl[id]  = 1'b1;
        if (!owner_known[id]) begin
          owner_known[id] = 1'b1;
          known_ids.push_back(id);
        end
      end
      OP_EDIT: begin
        prio_tbl[id] = prio[PRIO_BITS-1:0];
        live_tbl[id] = 1'b1;
      end
      OP_REMOVE: live_tbl[id] = 1'b0;
      default: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (live_tbl[i] && (!win.found || prio_tbl[i] >= best)) begin
            win.found = 1'b1;
            win.id    = TASK_ID_W'(i);
            best      = prio_tbl[i];
          end
        end
        if (win.found) begin
          win.owner         = owner_tbl[win.id];
          live_tbl[win.id]  = 1'b0;
        end
        pending_results.push_back(win);
      end
    endcase
  endtask

  // Offer one request word; returns on the edge that accepts it. Valid is
  // only dropped for a gap, so it is never lowered and raised in one step.
  task automatic offer_request(op_e op, logic [TASK_ID_W-1:0] id,
                               logic [USER_ID_W-1:0] user,
                               logic [PRIO_REQ_W-1:0] prio);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    op_i           <= op;
    task_id_i      <= id;
    user_id_i      <= user;
    priority_req_i <= prio;
    // sample mid-cycle, where both sides are settled
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    @(posedge clk_i);
    apply_request(op, id, user, prio);
  endtask

  // Result check: the word is taken at the next rising edge, so compare now.
  always @(negedge clk_i) begin : result_check
    result_t due;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result word found=%0b owner=%h task=%0d",
                 $time, found_o, owner_out_o, task_out_o);
      end else begin
        due = pending_results.pop_front();
        if (found_o !== due.found) begin
          mismatch_count++;
          $display("%0t: found expected %0b actual %0b", $time, due.found, found_o);
        end
        if (owner_out_o !== due.owner) begin
          mismatch_count++;
          $display("%0t: owner expected %h actual %h", $time, due.owner, owner_out_o);
        end
        if (task_out_o !== due.id) begin
          mismatch_count++;
          $display("%0t: task expected %0d actual %0d", $time, due.id, task_out_o);
        end
      end
    end
  end

  // Ids lean towards both ends of the table so that edits and removes
  // often land on live tasks.
  function automatic logic [TASK_ID_W-1:0] draw_task_id();
    case ($urandom_range(3))
      0:       return TASK_ID_W'($urandom_range(15));
      1:       return TASK_ID_W'(SLOTS - 16 + $urandom_range(15));
      default: return TASK_ID_W'($urandom_range(SLOTS - 1));
    endcase
  endfunction

  // Small values give plenty of equal priorities; extremes now and then.
  function automatic logic [PRIO_REQ_W-1:0] draw_priority();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return PRIO_REQ_W'($urandom_range(3));
      default: return PRIO_REQ_W'($urandom());
    endcase
  endfunction

  // Plain random field values, for fields the operation ignores.
  function automatic logic [TASK_ID_W-1:0] rnd_id();
    return TASK_ID_W'($urandom());
  endfunction

  function automatic logic [USER_ID_W-1:0] rnd_user();
    return USER_ID_W'($urandom());
  endfunction

  function automatic logic [PRIO_REQ_W-1:0] rnd_prio();
    return PRIO_REQ_W'($urandom());
  endfunction

  // Empty table, field extremes, ties, remove and revive-on-edit.
  task automatic test_directed();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());         // empty table
    offer_request(OP_ADD, '0, '0, '0);
    offer_request(OP_ADD, '1, '1, '1);
    offer_request(OP_ADD, 10'd512, 16'hA5A5, '1);                      // ties id 1023
    offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());
    offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());
    offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());
    offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());         // drained
    offer_request(OP_REMOVE, 10'd300, rnd_user(), rnd_prio());        // not live
    offer_request(OP_EDIT, '1, rnd_user(), 30'd5);                     // revive executed
    offer_request(OP_ADD, 10'd7, 16'h1234, 30'd5);
    offer_request(OP_REMOVE, 10'd7, rnd_user(), rnd_prio());
    offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());
    offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());
    offer_request(OP_EDIT, 10'd7, rnd_user(), 30'h2AAA_AAAA);          // revive removed
    offer_request(OP_ADD, 10'd1, 16'h5555, 30'h1555_5555);
    offer_request(OP_ADD, 10'd1, 16'hAAAA, 30'h3FFF_FFFF);             // re-add overwrites
    offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());
    offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());
    offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());
  endtask

  // Result channel held off for several scans while words keep coming, so
  // the output register fills and the block must stall its request side.
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_left    = 4 * (SLOTS + 8);
    for (int n = 0; n < 12; n++) begin
      if (n % 3 == 2)
        offer_request(OP_EXEC, rnd_id(), rnd_user(), rnd_prio());
      else
        offer_request(OP_ADD, draw_task_id(), rnd_user(), draw_priority());
    end
  endtask

  // Random mix with the given idling; edits go to ids with a known owner.
  task automatic test_random_phase(int tx_pct, int rx_pct, int count);
    int                   pick;
    op_e                  op;
    logic [TASK_ID_W-1:0] id;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      id   = draw_task_id();
      if (pick < 40)      op = OP_ADD;
      else if (pick < 60) op = OP_EDIT;
      else if (pick < 80) op = OP_REMOVE;
      else                op = OP_EXEC;
      if (op == OP_EDIT && known_ids.size() == 0)
        op = OP_ADD;
      if ((op == OP_EDIT || (op == OP_REMOVE && pick < 75)) && known_ids.size() != 0)
        id = known_ids[$urandom_range(known_ids.size() - 1)];
      offer_request(op, id, rnd_user(), draw_priority());
    end
  endtask

  initial begin
    rst_ni         <= 1'b0;
    in_valid_i     <= 1'b0;
    op_i           <= OP_ADD;
    task_id_i      <= '0;
    user_id_i      <= '0;
    priority_req_i <= '0;
    out_stall_i    <= 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      live_tbl[i]    = 1'b0;
      prio_tbl[i]    = '0;
      owner_tbl[i]   = '0;
      owner_known[i] = 1'b0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // the clearing pass after reset shows up as in_stall_o; offering waits it out
    test_directed();
    test_backpressure();
    test_random_phase(0, 0, 140);
    test_random_phase(47, 0, 140);
    test_random_phase(0, 47, 140);
    test_random_phase(32, 32, 140);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // a stray result word would show up within one more scan
    repeat (SLOTS + 16) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* task_priority_scheduler.f */
+incdir+rtl
rtl/tps_pkg.sv
rtl/tps_ctrl.sv
rtl/tps_datapath.sv
rtl/task_priority_scheduler.sv
rtl/tps_checker.sv
verif/task_priority_scheduler_tb.sv
